>>> sv/rwcp_pkg.sv
// Shared types and constants for the RIFF/WAVE chunk parser.
// Used by the parsing back end and the top level.
package rwcp_pkg;

  localparam int OFFSET_BITS = 32;
  localparam int CMP_BITS = ((OFFSET_BITS > 32) ? OFFSET_BITS : 32) + 2;
  localparam int CFG_INDEX_BITS = 1;
  localparam int CFG_DATA_BITS = 32;

  localparam logic [CFG_INDEX_BITS-1:0] REG_TOTAL_BYTES = 1'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_MIN_FORMAT_BYTES = 1'd1;

  localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
  localparam logic [31:0] TAG_WAVE = 32'h5741_5645;
  localparam logic [31:0] TAG_FMT = 32'h666D_7420;
  localparam logic [31:0] TAG_DATA = 32'h6461_7461;

  localparam logic [31:0] HEADER_BYTES = 32'd12;
  localparam int CHUNK_HEAD_BYTES = 8;
  localparam logic [7:0] MIN_FORMAT_RESET = 8'd18;

  localparam logic [2:0] ROLE_HEADER = 3'd0;
  localparam logic [2:0] ROLE_ID = 3'd1;
  localparam logic [2:0] ROLE_SIZE = 3'd2;
  localparam logic [2:0] ROLE_FMT = 3'd3;
  localparam logic [2:0] ROLE_DATA = 3'd4;
  localparam logic [2:0] ROLE_OTHER = 3'd5;
  localparam logic [2:0] ROLE_PAD = 3'd6;
  localparam logic [2:0] ROLE_IGNORED = 3'd7;

  localparam logic [2:0] ST_OK = 3'd0;
  localparam logic [2:0] ST_TOO_SMALL = 3'd1;
  localparam logic [2:0] ST_BAD_TAG = 3'd2;
  localparam logic [2:0] ST_TRUNCATED = 3'd3;
  localparam logic [2:0] ST_NO_USABLE = 3'd4;

  typedef enum logic [4:0] {
    PH_HEADER  = 5'b00001,
    PH_ID      = 5'b00010,
    PH_SIZE    = 5'b00100,
    PH_PAYLOAD = 5'b01000,
    PH_PAD     = 5'b10000
  } phase_t;

  typedef enum logic [1:0] {
    KIND_OTHER = 2'd0,
    KIND_FMT   = 2'd1,
    KIND_DATA  = 2'd2
  } kind_t;

  typedef struct packed {
    logic [31:0] total_bytes;
    logic [7:0]  min_format_bytes;
  } cfg_t;

endpackage

>>> sv/rwcp_byte_if.sv
// Valid/ready channel carrying one file byte per beat.
// Stands alone; used by the top level, the queue and the parser.
interface rwcp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] file_byte;

  modport source (output valid, output file_byte, input ready);
  modport sink (input valid, input file_byte, output ready);
endinterface

>>> sv/rwcp_result_if.sv
// Valid/ready channel carrying one tagged parse result per beat.
// Stands alone; used by the parser and the top level.
interface rwcp_result_if;
  logic        valid;
  logic        ready;
  logic [7:0]  byte_echo;
  logic [2:0]  byte_role;
  logic        finished;
  logic [2:0]  status;
  logic [31:0] data_start;
  logic [31:0] data_length;
  logic [31:0] format_length;

  modport source (output valid, output byte_echo, output byte_role, output finished,
                  output status, output data_start, output data_length,
                  output format_length, input ready);
  modport sink (input valid, input byte_echo, input byte_role, input finished,
                input status, input data_start, input data_length,
                input format_length, output ready);
endinterface

>>> sv/rwcp_front.sv
// Input front end: a two-entry byte queue that decouples acceptance from parsing.
// Depends on rwcp_byte_if.
module rwcp_front (
  input  logic         clk,
  input  logic         rst,
  rwcp_byte_if.sink    bytes,
  rwcp_byte_if.source  queue
);

  logic [7:0] mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  logic       pop;

  assign bytes.ready = (count != 2'd2);
  assign queue.valid = (count != 2'd0);
  assign queue.file_byte = mem[rd_ptr];
  assign push = bytes.valid && bytes.ready;
  assign pop = queue.valid && queue.ready;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= bytes.file_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst) count <= 2'd2)
    else $error("Byte queue holds more than two entries.");

  a_count_track: assert property (@(posedge clk) disable iff (rst)
    push && !pop |=> count == $past(count) + 2'd1)
    else $error("Byte queue count missed a push.");

endmodule

>>> sv/rwcp_back.sv
// Parsing back end: walks the header and chunks one byte per cycle while results are
// accepted, and registers the tagged result. Depends on rwcp_pkg, rwcp_byte_if and rwcp_result_if.
module rwcp_back (
  input  logic                 clk,
  input  logic                 rst,
  input  rwcp_pkg::cfg_t       cfg,
  rwcp_byte_if.sink            queue,
  rwcp_result_if.source        results
);

  logic [rwcp_pkg::OFFSET_BITS-1:0] position, position_next;
  rwcp_pkg::phase_t phase, phase_next;
  logic [31:0] id_shift, id_shift_next;
  logic [31:0] size_shift, size_shift_next;
  logic [31:0] payload_left, payload_left_next;
  logic        pad_pending, pad_pending_next;
  rwcp_pkg::kind_t chunk_kind, chunk_kind_next;
  logic [31:0] fmt_size, fmt_size_next;
  logic [31:0] data_offset_reg, data_offset_next;
  logic [31:0] data_size_reg, data_size_next;
  logic [2:0]  error_code, error_code_next;
  logic        stopped, stopped_next;

  logic [2:0]  role;
  logic        fin;
  logic        pop;
  logic [7:0]  b;

  logic [rwcp_pkg::OFFSET_BITS:0] pos1;
  logic [rwcp_pkg::CMP_BITS-1:0]  total_w;
  logic        bnd_over;
  logic        pad_over;
  logic        trunc_over;
  logic [31:0] size_new;
  logic [31:0] left_dec;
  logic [31:0] fmt_eff;
  logic [31:0] data_eff;
  logic [2:0]  final_code;

  assign b = queue.file_byte;
  assign queue.ready = !results.valid || results.ready;
  assign pop = queue.valid && queue.ready;

  assign pos1 = {1'b0, position} + 1'b1;
  assign total_w = rwcp_pkg::CMP_BITS'(cfg.total_bytes);
  assign size_new = {b, size_shift[31:8]};
  assign left_dec = payload_left - 32'd1;

  assign bnd_over = (rwcp_pkg::CMP_BITS'(pos1) + rwcp_pkg::CMP_BITS'(rwcp_pkg::CHUNK_HEAD_BYTES))
                    > total_w;
  assign pad_over = (rwcp_pkg::CMP_BITS'(position)
                     + rwcp_pkg::CMP_BITS'(rwcp_pkg::CHUNK_HEAD_BYTES + 2)) > total_w;
  assign trunc_over = (rwcp_pkg::CMP_BITS'(pos1) + rwcp_pkg::CMP_BITS'(size_new)) > total_w;

  // The end check in the size phase sees the chunk that is being recorded.
  assign fmt_eff = (phase == rwcp_pkg::PH_SIZE && id_shift == rwcp_pkg::TAG_FMT)
                   ? size_new : fmt_size;
  assign data_eff = (phase == rwcp_pkg::PH_SIZE && id_shift == rwcp_pkg::TAG_DATA)
                    ? size_new : data_size_reg;
  assign final_code = (fmt_eff < {24'd0, cfg.min_format_bytes} || data_eff == 32'd0)
                      ? rwcp_pkg::ST_NO_USABLE : rwcp_pkg::ST_OK;

  always_comb begin
    position_next = position;
    phase_next = phase;
    id_shift_next = id_shift;
    size_shift_next = size_shift;
    payload_left_next = payload_left;
    pad_pending_next = pad_pending;
    chunk_kind_next = chunk_kind;
    fmt_size_next = fmt_size;
    data_offset_next = data_offset_reg;
    data_size_next = data_size_reg;
    error_code_next = error_code;
    stopped_next = stopped;
    role = rwcp_pkg::ROLE_IGNORED;
    fin = 1'b0;
    if (!stopped) begin
      position_next = position + 1'b1;
      case (phase)
        rwcp_pkg::PH_HEADER: begin
          role = rwcp_pkg::ROLE_HEADER;
          id_shift_next = {id_shift[23:0], b};
          if (position == '0 && cfg.total_bytes < rwcp_pkg::HEADER_BYTES) begin
            fin = 1'b1;
            error_code_next = rwcp_pkg::ST_TOO_SMALL;
          end else if (position == rwcp_pkg::OFFSET_BITS'(3)
                       && id_shift_next != rwcp_pkg::TAG_RIFF) begin
            fin = 1'b1;
            error_code_next = rwcp_pkg::ST_BAD_TAG;
          end else if (position == rwcp_pkg::OFFSET_BITS'(11)) begin
            if (id_shift_next != rwcp_pkg::TAG_WAVE) begin
              fin = 1'b1;
              error_code_next = rwcp_pkg::ST_BAD_TAG;
            end else if (bnd_over) begin
              fin = 1'b1;
              error_code_next = final_code;
            end else begin
              phase_next = rwcp_pkg::PH_ID;
              payload_left_next = 32'd4;
              id_shift_next = 32'd0;
              pad_pending_next = 1'b0;
            end
          end
        end
        rwcp_pkg::PH_ID: begin
          role = rwcp_pkg::ROLE_ID;
          id_shift_next = {id_shift[23:0], b};
          payload_left_next = left_dec;
          if (left_dec == 32'd0) begin
            phase_next = rwcp_pkg::PH_SIZE;
            payload_left_next = 32'd4;
            size_shift_next = 32'd0;
          end
        end
        rwcp_pkg::PH_SIZE: begin
          role = rwcp_pkg::ROLE_SIZE;
          size_shift_next = size_new;
          payload_left_next = left_dec;
          if (left_dec == 32'd0) begin
            if (trunc_over) begin
              fin = 1'b1;
              error_code_next = rwcp_pkg::ST_TRUNCATED;
            end else begin
              if (id_shift == rwcp_pkg::TAG_FMT) begin
                chunk_kind_next = rwcp_pkg::KIND_FMT;
                fmt_size_next = size_new;
              end else if (id_shift == rwcp_pkg::TAG_DATA) begin
                chunk_kind_next = rwcp_pkg::KIND_DATA;
                data_offset_next = 32'(pos1);
                data_size_next = size_new;
              end else begin
                chunk_kind_next = rwcp_pkg::KIND_OTHER;
              end
              if (size_new == 32'd0) begin
                if (bnd_over) begin
                  fin = 1'b1;
                  error_code_next = final_code;
                end else begin
                  phase_next = rwcp_pkg::PH_ID;
                  payload_left_next = 32'd4;
                  id_shift_next = 32'd0;
                  pad_pending_next = 1'b0;
                end
              end else begin
                phase_next = rwcp_pkg::PH_PAYLOAD;
                payload_left_next = size_new;
                pad_pending_next = size_new[0];
              end
            end
          end
        end
        rwcp_pkg::PH_PAYLOAD: begin
          if (chunk_kind == rwcp_pkg::KIND_FMT) begin
            role = rwcp_pkg::ROLE_FMT;
          end else if (chunk_kind == rwcp_pkg::KIND_DATA) begin
            role = rwcp_pkg::ROLE_DATA;
          end else begin
            role = rwcp_pkg::ROLE_OTHER;
          end
          if (payload_left != 32'd0) begin
            payload_left_next = left_dec;
          end
          if (payload_left_next == 32'd0) begin
            if (pad_pending) begin
              if (pad_over) begin
                fin = 1'b1;
                error_code_next = final_code;
              end else begin
                phase_next = rwcp_pkg::PH_PAD;
              end
            end else if (bnd_over) begin
              fin = 1'b1;
              error_code_next = final_code;
            end else begin
              phase_next = rwcp_pkg::PH_ID;
              payload_left_next = 32'd4;
              id_shift_next = 32'd0;
              pad_pending_next = 1'b0;
            end
          end
        end
        rwcp_pkg::PH_PAD: begin
          role = rwcp_pkg::ROLE_PAD;
          pad_pending_next = 1'b0;
          if (bnd_over) begin
            fin = 1'b1;
            error_code_next = final_code;
          end else begin
            phase_next = rwcp_pkg::PH_ID;
            payload_left_next = 32'd4;
            id_shift_next = 32'd0;
          end
        end
        default: begin
          role = rwcp_pkg::ROLE_IGNORED;
          fin = 1'b1;
          error_code_next = rwcp_pkg::ST_OK;
        end
      endcase
      if (fin) begin
        stopped_next = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      position <= '0;
      phase <= rwcp_pkg::PH_HEADER;
      id_shift <= 32'd0;
      size_shift <= 32'd0;
      payload_left <= 32'd0;
      pad_pending <= 1'b0;
      chunk_kind <= rwcp_pkg::KIND_OTHER;
      fmt_size <= 32'd0;
      data_offset_reg <= 32'd0;
      data_size_reg <= 32'd0;
      error_code <= rwcp_pkg::ST_OK;
      stopped <= 1'b0;
    end else if (pop) begin
      position <= position_next;
      phase <= phase_next;
      id_shift <= id_shift_next;
      size_shift <= size_shift_next;
      payload_left <= payload_left_next;
      pad_pending <= pad_pending_next;
      chunk_kind <= chunk_kind_next;
      fmt_size <= fmt_size_next;
      data_offset_reg <= data_offset_next;
      data_size_reg <= data_size_next;
      error_code <= error_code_next;
      stopped <= stopped_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      results.valid <= 1'b0;
    end else if (pop) begin
      results.valid <= 1'b1;
    end else if (results.ready) begin
      results.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      results.byte_echo <= b;
      results.byte_role <= role;
      results.finished <= fin;
      results.status <= stopped_next ? error_code_next : rwcp_pkg::ST_OK;
      results.data_start <= data_offset_next;
      results.data_length <= data_size_next;
      results.format_length <= fmt_size_next;
    end
  end

  a_stop_sticky: assert property (@(posedge clk) disable iff (rst) stopped |=> stopped)
    else $error("Parser left the stopped state without a reset.");

  a_fin_stops: assert property (@(posedge clk) disable iff (rst)
    pop && fin |=> stopped && results.valid && results.finished)
    else $error("Final byte did not stop the parser.");

  a_ignored_after_stop: assert property (@(posedge clk) disable iff (rst)
    pop && stopped |=> results.byte_role == rwcp_pkg::ROLE_IGNORED && !results.finished
                       && $stable(position))
    else $error("Byte after the end was not ignored.");

endmodule

>>> sv/riff_wave_chunk_parser.sv
// RIFF/WAVE chunk parser, top level: takes one file byte per beat and returns one
// tagged result per byte. A byte is accepted into a two-entry queue and its result
// is registered in the output register of the parsing back end; the sustained rate is
// one byte per cycle while results are accepted, set by the state update of the back end.
// Write total_bytes (index 0) and min_format_bytes (index 1, reset 18) while idle.
// Depends on rwcp_pkg, rwcp_byte_if, rwcp_result_if, rwcp_front and rwcp_back.
module riff_wave_chunk_parser (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                write_enable,
  input  logic [rwcp_pkg::CFG_INDEX_BITS-1:0] write_index,
  input  logic [rwcp_pkg::CFG_DATA_BITS-1:0]  write_data,
  rwcp_byte_if.sink                           bytes,
  rwcp_result_if.source                       results
);

  rwcp_pkg::cfg_t cfg;

  rwcp_byte_if queue ();

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.total_bytes <= 32'd0;
      cfg.min_format_bytes <= rwcp_pkg::MIN_FORMAT_RESET;
    end else if (write_enable) begin
      case (write_index)
        rwcp_pkg::REG_TOTAL_BYTES: cfg.total_bytes <= write_data[31:0];
        rwcp_pkg::REG_MIN_FORMAT_BYTES: cfg.min_format_bytes <= write_data[7:0];
        default: begin
        end
      endcase
    end
  end

  rwcp_front u_front (
    .clk   (clk),
    .rst   (rst),
    .bytes (bytes),
    .queue (queue.source)
  );

  rwcp_back u_back (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .queue   (queue.sink),
    .results (results)
  );

endmodule
